@@ rtl/core/imgd_pkg.sv @@
// Shared types, register indexes and constant tables for the IMU motion and gesture detector.
`default_nettype none

package imgd_pkg;

   // Item kinds on the request channel.
   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_READ   = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_GESTURES_ENABLED   = 2'd0;
   localparam logic [1:0] CSR_SENSITIVITY        = 2'd1;
   localparam logic [1:0] CSR_SAMPLE_INTERVAL_MS = 2'd2;
   localparam logic [1:0] CSR_COOLDOWN_MS        = 2'd3;

   // Configuration reset values.
   localparam logic        RST_GESTURES_ENABLED   = 1'b1;
   localparam logic [7:0]  RST_SENSITIVITY        = 8'd5;
   localparam logic [15:0] RST_SAMPLE_INTERVAL_MS = 16'd20;
   localparam logic [15:0] RST_COOLDOWN_MS        = 16'd500;

   // Motion limits in raw sensor units.
   localparam logic [17:0] MOTION_DELTA_LIMIT = 18'd1024;
   localparam logic [15:0] MOTION_GYRO_LIMIT  = 16'd2560;

   // Accel Z rests at one g after reset.
   localparam logic signed [15:0] ONE_G = 16'sd4096;

   typedef enum logic [1:0] {
      GESTURE_NONE       = 2'd0,
      GESTURE_SHAKE      = 2'd1,
      GESTURE_TILT_RIGHT = 2'd2,
      GESTURE_TILT_LEFT  = 2'd3
   } imgd_gesture_type;

   typedef struct packed {
      logic               func;
      logic        [31:0] time_ms;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [15:0] gyro_x;
      logic signed [15:0] gyro_y;
      logic signed [15:0] gyro_z;
   } imgd_req_type;

   typedef struct packed {
      logic       sample_taken;
      logic       motion_detected;
      logic [1:0] gesture;
   } imgd_rsp_type;

   typedef struct packed {
      logic        gestures_enabled;
      logic [7:0]  sensitivity;
      logic [15:0] sample_interval_ms;
      logic [15:0] cooldown_ms;
   } imgd_cfg_type;

   // Detector state apart from the filtered accel X, whose width follows a parameter.
   typedef struct packed {
      logic signed [15:0] previous_x;
      logic signed [15:0] previous_y;
      logic signed [15:0] previous_z;
      logic        [31:0] last_sample_time;
      logic        [31:0] last_gesture_time;
      logic        [1:0]  latched_gesture;
      logic               motion_flag;
   } imgd_state_type;

   // Squared shake limit ((280 - 15*s) * 64)^2 for a clamped sensitivity s.
   function automatic logic [31:0] shake_limit_sq(input logic [3:0] sens);
      logic [31:0] lim;
      begin
         case (sens)
            4'd1:    lim = 32'd287641600;
            4'd2:    lim = 32'd256000000;
            4'd3:    lim = 32'd226201600;
            4'd4:    lim = 32'd198246400;
            4'd5:    lim = 32'd172134400;
            4'd6:    lim = 32'd147865600;
            4'd7:    lim = 32'd125440000;
            4'd8:    lim = 32'd104857600;
            4'd9:    lim = 32'd86118400;
            4'd10:   lim = 32'd69222400;
            default: lim = 32'd287641600;
         endcase
         return lim;
      end
   endfunction

   // Tilt limit in thousandths of a g, 550 - 35*s, for a clamped sensitivity s.
   function automatic logic [9:0] tilt_limit_mg(input logic [3:0] sens);
      logic [9:0] lim;
      begin
         case (sens)
            4'd1:    lim = 10'd515;
            4'd2:    lim = 10'd480;
            4'd3:    lim = 10'd445;
            4'd4:    lim = 10'd410;
            4'd5:    lim = 10'd375;
            4'd6:    lim = 10'd340;
            4'd7:    lim = 10'd305;
            4'd8:    lim = 10'd270;
            4'd9:    lim = 10'd235;
            4'd10:   lim = 10'd200;
            default: lim = 10'd515;
         endcase
         return lim;
      end
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/imgd_step.sv @@
// Combinational update of the detector state and the result for one item.
`default_nettype none

module imgd_step #(
   parameter int FILTER_FRACTION_BITS = 4
) (
   input  wire imgd_pkg::imgd_req_type   item,
   input  wire imgd_pkg::imgd_cfg_type   cfg,
   input  wire imgd_pkg::imgd_state_type state_cur,
   input  wire logic signed [FILTER_FRACTION_BITS+16:0] filt_x_cur,
   output imgd_pkg::imgd_state_type      state_next,
   output logic signed [FILTER_FRACTION_BITS+16:0]      filt_x_next,
   output imgd_pkg::imgd_rsp_type        rsp
);

   localparam int FX_W  = FILTER_FRACTION_BITS + 17;
   localparam int SUM_W = FX_W + 2;
   localparam int CMP_W = FX_W + 11;
   localparam int TILT_SHIFT = FILTER_FRACTION_BITS + 12;

   logic signed [SUM_W-1:0] ax_scaled;
   logic signed [SUM_W-1:0] fx_ext;
   logic signed [SUM_W-1:0] filt_sum;
   logic signed [FX_W-1:0]  filt_new;

   logic signed [16:0] dx;
   logic signed [16:0] dy;
   logic signed [16:0] dz;
   logic        [15:0] adx;
   logic        [15:0] ady;
   logic        [15:0] adz;
   logic        [17:0] delta_sum;
   logic signed [16:0] gx_ext;
   logic signed [16:0] gy_ext;
   logic        [15:0] agx;
   logic        [15:0] agy;
   logic               motion_new;

   logic signed [31:0] sq_x;
   logic signed [31:0] sq_y;
   logic signed [31:0] sq_z;
   logic        [31:0] mag2;

   logic        [3:0]  sens;
   logic signed [CMP_W-1:0] fx_mg;
   logic signed [CMP_W-1:0] tilt_lim;
   logic signed [CMP_W-1:0] tilt_lim_neg;

   logic [31:0] since_sample;
   logic [31:0] since_gesture;
   logic        gate_ok;
   logic        cool_ok;

   always_comb begin
      // Low-pass filter: floor((x * 2^F + 3 * filtered) / 4), the floor is an arithmetic shift.
      ax_scaled = SUM_W'(item.accel_x) <<< FILTER_FRACTION_BITS;
      fx_ext    = SUM_W'(filt_x_cur);
      filt_sum  = ax_scaled + (fx_ext <<< 1) + fx_ext;
      filt_new  = filt_sum[SUM_W-1:2];

      dx  = 17'(item.accel_x) - 17'(state_cur.previous_x);
      dy  = 17'(item.accel_y) - 17'(state_cur.previous_y);
      dz  = 17'(item.accel_z) - 17'(state_cur.previous_z);
      adx = dx[16] ? 16'(-dx) : dx[15:0];
      ady = dy[16] ? 16'(-dy) : dy[15:0];
      adz = dz[16] ? 16'(-dz) : dz[15:0];
      delta_sum = 18'(adx) + 18'(ady) + 18'(adz);

      gx_ext = 17'(item.gyro_x);
      gy_ext = 17'(item.gyro_y);
      agx = gx_ext[16] ? 16'(-gx_ext) : gx_ext[15:0];
      agy = gy_ext[16] ? 16'(-gy_ext) : gy_ext[15:0];
      motion_new = (delta_sum > imgd_pkg::MOTION_DELTA_LIMIT) ||
                   (agx > imgd_pkg::MOTION_GYRO_LIMIT) ||
                   (agy > imgd_pkg::MOTION_GYRO_LIMIT);

      // Each square is at most 2^30, so the sum of three fits 32 bits unsigned.
      sq_x = item.gyro_x * item.gyro_x;
      sq_y = item.gyro_y * item.gyro_y;
      sq_z = item.gyro_z * item.gyro_z;
      mag2 = 32'(sq_x) + 32'(sq_y) + 32'(sq_z);

      if (cfg.sensitivity == 8'd0) begin
         sens = 4'd1;
      end else if (cfg.sensitivity > 8'd10) begin
         sens = 4'd10;
      end else begin
         sens = cfg.sensitivity[3:0];
      end

      fx_mg        = CMP_W'(filt_new) * CMP_W'(1000);
      tilt_lim     = CMP_W'(imgd_pkg::tilt_limit_mg(sens)) <<< TILT_SHIFT;
      tilt_lim_neg = -tilt_lim;

      since_sample  = item.time_ms - state_cur.last_sample_time;
      since_gesture = item.time_ms - state_cur.last_gesture_time;
      gate_ok = since_sample >= 32'(cfg.sample_interval_ms);
      cool_ok = since_gesture >= 32'(cfg.cooldown_ms);

      state_next  = state_cur;
      filt_x_next = filt_x_cur;
      rsp.sample_taken    = 1'b0;
      rsp.motion_detected = state_cur.motion_flag;
      rsp.gesture         = state_cur.latched_gesture;

      if (item.func == imgd_pkg::FUNC_READ) begin
         state_next.latched_gesture = imgd_pkg::GESTURE_NONE;
      end else if (gate_ok) begin
         rsp.sample_taken           = 1'b1;
         state_next.last_sample_time = item.time_ms;
         filt_x_next                = filt_new;
         state_next.previous_x      = item.accel_x;
         state_next.previous_y      = item.accel_y;
         state_next.previous_z      = item.accel_z;
         state_next.motion_flag     = motion_new;
         if (cfg.gestures_enabled && cool_ok) begin
            if (mag2 > imgd_pkg::shake_limit_sq(sens)) begin
               state_next.latched_gesture   = imgd_pkg::GESTURE_SHAKE;
               state_next.last_gesture_time = item.time_ms;
            end else if (fx_mg > tilt_lim) begin
               state_next.latched_gesture   = imgd_pkg::GESTURE_TILT_RIGHT;
               state_next.last_gesture_time = item.time_ms;
            end else if (fx_mg < tilt_lim_neg) begin
               state_next.latched_gesture   = imgd_pkg::GESTURE_TILT_LEFT;
               state_next.last_gesture_time = item.time_ms;
            end
         end
         rsp.motion_detected = state_next.motion_flag;
         rsp.gesture         = state_next.latched_gesture;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/imu_motion_gesture_detector_top.sv @@
// Top level of the IMU motion and gesture detector: channels, registers and state.
//
// Usage: each request transfer carries either a six-axis sample with a millisecond
// timestamp (func = sample) or a gesture read (func = read). Every request yields
// exactly one response transfer with sample_taken, motion_detected and gesture,
// in request order. Configuration writes on the csr_ channel are always ready and
// should be issued only while no request is in flight.
// A request is held in the request register and then in the response register, from
// which it is shown on rsp_. Throughput is one item per cycle while the receiver does
// not stall: the whole update is one combinational step (three 16x16 squarers, the filter
// adder and the tilt compare) between the request register and the response register.
// When the receiver stalls, the response register holds its item and the request
// register takes nothing new once it is full; req_stall rises in that case.
// Reset clears the detector state, with previous accel Z at one g, and loads the
// defaults (gestures on, sensitivity 5, 20 ms sample interval, 500 ms cooldown).
`default_nettype none

module imu_motion_gesture_detector_top #(
   parameter int FILTER_FRACTION_BITS = 4
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire imgd_pkg::imgd_req_type  req_data,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output imgd_pkg::imgd_rsp_type       rsp_data,
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire logic [1:0]              csr_index,
   input  wire logic [15:0]             csr_wdata
);

   localparam int FX_W = FILTER_FRACTION_BITS + 17;

   imgd_pkg::imgd_req_type   item_ff;
   logic                     item_valid_ff;
   imgd_pkg::imgd_cfg_type   cfg_ff;
   imgd_pkg::imgd_cfg_type   cfg_in;
   imgd_pkg::imgd_state_type state_ff;
   imgd_pkg::imgd_state_type state_in;
   logic signed [FX_W-1:0]   filt_x_ff;
   logic signed [FX_W-1:0]   filt_x_in;
   imgd_pkg::imgd_rsp_type   rsp_ff;
   imgd_pkg::imgd_rsp_type   rsp_in;
   logic                     rsp_valid_ff;

   logic out_free;
   logic advance;
   logic req_take;

   // The response register can take a new item when empty or when its item leaves now.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = item_valid_ff && out_free;
   assign req_stall = item_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   imgd_step #(
      .FILTER_FRACTION_BITS(FILTER_FRACTION_BITS)
   ) u_step (
      .item        (item_ff),
      .cfg         (cfg_ff),
      .state_cur   (state_ff),
      .filt_x_cur  (filt_x_ff),
      .state_next  (state_in),
      .filt_x_next (filt_x_in),
      .rsp         (rsp_in)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            imgd_pkg::CSR_GESTURES_ENABLED:   cfg_in.gestures_enabled   = csr_wdata[0];
            imgd_pkg::CSR_SENSITIVITY:        cfg_in.sensitivity        = csr_wdata[7:0];
            imgd_pkg::CSR_SAMPLE_INTERVAL_MS: cfg_in.sample_interval_ms = csr_wdata;
            imgd_pkg::CSR_COOLDOWN_MS:        cfg_in.cooldown_ms        = csr_wdata;
            default:                          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gestures_enabled   <= imgd_pkg::RST_GESTURES_ENABLED;
         cfg_ff.sensitivity        <= imgd_pkg::RST_SENSITIVITY;
         cfg_ff.sample_interval_ms <= imgd_pkg::RST_SAMPLE_INTERVAL_MS;
         cfg_ff.cooldown_ms        <= imgd_pkg::RST_COOLDOWN_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_take) begin
         item_valid_ff <= 1'b1;
      end else if (advance) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.previous_x        <= '0;
         state_ff.previous_y        <= '0;
         state_ff.previous_z        <= imgd_pkg::ONE_G;
         state_ff.last_sample_time  <= '0;
         state_ff.last_gesture_time <= '0;
         state_ff.latched_gesture   <= imgd_pkg::GESTURE_NONE;
         state_ff.motion_flag       <= 1'b0;
         filt_x_ff                  <= '0;
      end else if (advance) begin
         state_ff  <= state_in;
         filt_x_ff <= filt_x_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire
